@@ rtl/core/bds2x2_pkg.sv @@
// shared constants and types for the 2x2 box downsampler
package bds2x2_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int NUM_COMP   = 4;
    localparam int COMP_W     = 8;
    localparam int PAIR_W     = COMP_W + 1;
    localparam int SUM_W      = COMP_W + 2;
    localparam int SIZE_W     = 13;
    localparam int POS_W      = 12;
    localparam int CC_W       = 3;
    localparam int CFG_IDX_W  = 2;

    typedef logic [COMP_W-1:0]    comp_t;
    typedef logic [PAIR_W-1:0]    pair_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_COMP_COUNT = 2'd2
    } cfg_reg_t;

    // zero reads as one, anything above the limit reads as the limit
    function automatic size_t clamp_size(input size_t v, input size_t maxv);
        size_t r;
        if (v == '0) begin
            r = size_t'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/box_downsample_2x2_core.sv @@
// top level of the streaming 2x2 box-filter downsampler
//
// Source pixels enter on the s_ channel in raster order, one pixel of four
// 8-bit components per item. Each 2x2 source block gives one item on the m_
// channel, the floor of the block average per component; components at or
// above component_count read as zero. m_last_of_image marks the final result
// of an image. Odd last columns or rows are dropped; a width or height of one
// uses the single column or row twice.
// The cfg channel writes src_width (0), src_height (1), component_count (2);
// cfg_ready is always high and a write to any of these three restarts the
// image. Write it only while no item is in flight.
// Throughput is one pixel per clock while the receiver does not stall. The
// odd-row pixel that completes a block is registered with its line buffer
// read in the middle stage, and its average then into the output register.
// Even-row pair sums sit in a single-port line buffer of MAX_WIDTH/2 entries;
// an entry is always written a full row before it is read, so no forwarding.
// Reset sets a 1x1 image with four components and clears the counters; the
// line buffer is not cleared. A stalled receiver holds the output register,
// the middle stage then fills and s_ready drops until m_ready returns.
module box_downsample_2x2_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bds2x2_pkg::comp_t     s_in_c0,
    input  bds2x2_pkg::comp_t     s_in_c1,
    input  bds2x2_pkg::comp_t     s_in_c2,
    input  bds2x2_pkg::comp_t     s_in_c3,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bds2x2_pkg::comp_t     m_out_c0,
    output bds2x2_pkg::comp_t     m_out_c1,
    output bds2x2_pkg::comp_t     m_out_c2,
    output bds2x2_pkg::comp_t     m_out_c3,
    output logic                  m_last_of_image,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  bds2x2_pkg::cfg_idx_t  cfg_index,
    input  bds2x2_pkg::size_t     cfg_data
);
    import bds2x2_pkg::*;

    // configuration
    size_t                 w_reg;
    size_t                 h_reg;
    logic [CC_W-1:0]       cc_reg;
    logic                  cfg_we;
    logic                  restart;

    // position and held pixel
    logic [POS_W-1:0]      col_reg, col_next;
    logic [POS_W-1:0]      row_reg, row_next;
    comp_t                 held_reg [NUM_COMP];

    // accept-side decode
    logic                  s_acc;
    comp_t                 cur [NUM_COMP];
    pair_t                 pair [NUM_COMP];
    logic [NUM_COMP*PAIR_W-1:0] pair_packed;
    logic                  w_one, h_one;
    logic [POS_W-1:0]      wout, hout;
    logic [LINE_AW-1:0]    ox;
    logic [POS_W-2:0]      oy;
    logic                  have_pair, row_ok, emit, last_flag;

    // line buffer
    logic [NUM_COMP*PAIR_W-1:0] line_mem [LINE_DEPTH];
    logic [NUM_COMP*PAIR_W-1:0] rd_data_reg;
    logic                  mem_wr_en, mem_rd_en;

    // middle stage
    logic                  s1_valid_reg;
    logic [NUM_COMP*PAIR_W-1:0] s1_pair_reg;
    logic                  s1_h1_reg;
    logic                  s1_last_reg;
    logic                  s1_adv;
    comp_t                 avg [NUM_COMP];

    // output register
    logic                  out_valid_reg;
    comp_t                 out_c_reg [NUM_COMP];
    logic                  out_last_reg;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign restart   = cfg_we && (cfg_index == CFG_SRC_WIDTH || cfg_index == CFG_SRC_HEIGHT
                                  || cfg_index == CFG_COMP_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg  <= size_t'(1);
            h_reg  <= size_t'(1);
            cc_reg <= CC_W'(NUM_COMP);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  w_reg <= clamp_size(cfg_data, size_t'(MAX_WIDTH));
                CFG_SRC_HEIGHT: h_reg <= clamp_size(cfg_data, size_t'(MAX_HEIGHT));
                CFG_COMP_COUNT: begin
                    if (cfg_data[CC_W-1:0] == '0) begin
                        cc_reg <= CC_W'(1);
                    end else if (cfg_data[CC_W-1:0] > CC_W'(NUM_COMP)) begin
                        cc_reg <= CC_W'(NUM_COMP);
                    end else begin
                        cc_reg <= cfg_data[CC_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // flow control
    assign out_free = !out_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_acc    = s_valid && s_ready;

    // accept-side decode
    always_comb begin
        cur[0] = s_in_c0;
        cur[1] = (cc_reg > CC_W'(1)) ? s_in_c1 : '0;
        cur[2] = (cc_reg > CC_W'(2)) ? s_in_c2 : '0;
        cur[3] = (cc_reg > CC_W'(3)) ? s_in_c3 : '0;

        w_one = (w_reg == size_t'(1));
        h_one = (h_reg == size_t'(1));
        wout  = (w_reg[SIZE_W-1:1] == '0) ? POS_W'(1) : w_reg[SIZE_W-1:1];
        hout  = (h_reg[SIZE_W-1:1] == '0) ? POS_W'(1) : h_reg[SIZE_W-1:1];
        ox    = col_reg[POS_W-1:1];
        oy    = row_reg[POS_W-1:1];

        if (w_one) begin
            have_pair = (col_reg == '0);
        end else begin
            have_pair = col_reg[0] && ({1'b0, ox} < wout);
        end

        for (int c = 0; c < NUM_COMP; c++) begin
            pair[c] = w_one ? {cur[c], 1'b0} : (PAIR_W'(held_reg[c]) + PAIR_W'(cur[c]));
            pair_packed[c*PAIR_W +: PAIR_W] = pair[c];
        end

        row_ok    = ({1'b0, oy} < hout);
        emit      = have_pair && (h_one ? (row_reg == '0) : (row_ok && row_reg[0]));
        mem_wr_en = s_acc && have_pair && !h_one && row_ok && !row_reg[0];
        mem_rd_en = s_acc && have_pair && !h_one && row_ok && row_reg[0];
        last_flag = ({1'b0, ox} == wout - POS_W'(1))
                    && ({1'b0, oy} == hout - POS_W'(1));

        col_next = col_reg;
        row_next = row_reg;
        if ({1'b0, col_reg} + size_t'(1) >= w_reg) begin
            col_next = '0;
            if ({1'b0, row_reg} + size_t'(1) >= h_reg) begin
                row_next = '0;
            end else begin
                row_next = row_reg + POS_W'(1);
            end
        end else begin
            col_next = col_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int c = 0; c < NUM_COMP; c++) begin
                held_reg[c] <= '0;
            end
        end else if (restart) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int c = 0; c < NUM_COMP; c++) begin
                held_reg[c] <= '0;
            end
        end else if (s_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
            // even column pixel waits for its right neighbor
            if (!w_one && !col_reg[0]) begin
                for (int c = 0; c < NUM_COMP; c++) begin
                    held_reg[c] <= cur[c];
                end
            end
        end
    end

    // line buffer of even-row pair sums
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            line_mem[ox] <= pair_packed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_data_reg <= '0;
        end else if (mem_rd_en) begin
            rd_data_reg <= line_mem[ox];
        end
    end

    // middle stage: pair sums wait for the line buffer data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= emit;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pair_reg <= pair_packed;
            s1_h1_reg   <= h_one;
            s1_last_reg <= last_flag;
        end
    end

    always_comb begin
        logic [SUM_W-1:0] sum;
        for (int c = 0; c < NUM_COMP; c++) begin
            if (s1_h1_reg) begin
                sum = {s1_pair_reg[c*PAIR_W +: PAIR_W], 1'b0};
            end else begin
                sum = SUM_W'(rd_data_reg[c*PAIR_W +: PAIR_W])
                      + SUM_W'(s1_pair_reg[c*PAIR_W +: PAIR_W]);
            end
            avg[c] = (CC_W'(c) < cc_reg) ? sum[SUM_W-1:2] : '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                out_c_reg[c] <= avg[c];
            end
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_c0        = out_c_reg[0];
    assign m_out_c1        = out_c_reg[1];
    assign m_out_c2        = out_c_reg[2];
    assign m_out_c3        = out_c_reg[3];
    assign m_last_of_image = out_last_reg;

    // single-port line buffer never sees a read and a write together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
        else $error("line buffer read and write in the same cycle");

    // position stays inside the configured image
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, col_reg} < w_reg) && ({1'b0, row_reg} < h_reg))
        else $error("pixel position outside the image");

    // a stalled middle stage keeps its item and its line buffer data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=>
            (s1_valid_reg && $stable(s1_pair_reg) && $stable(rd_data_reg)))
        else $error("middle stage lost data while stalled");

endmodule

@@ tb/sv/box_downsample_2x2_core_tb.sv @@
// self-checking testbench for the streaming 2x2 box-filter downsampler
module box_downsample_2x2_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bds2x2_pkg::*;

    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 9;
    localparam int          RAND_ITEMS   = 350;
    localparam int          BIG_PIXELS   = 64;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam cfg_idx_t    CFG_UNUSED_IDX = 2'd3;

    typedef logic [NUM_COMP-1:0][COMP_W-1:0] pix_t;

    typedef struct packed {
        pix_t comp;
        logic eoi;
    } box_avg_t;

    typedef enum logic [1:0] {
        ROW_PIX,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        cfg_idx_t  idx;
        size_t     data;
        pix_t      pix;
        logic      typed;
        box_avg_t  want;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PULSE
    } rx_mode_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    comp_t    s_in_c0   = '0;
    comp_t    s_in_c1   = '0;
    comp_t    s_in_c2   = '0;
    comp_t    s_in_c3   = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    comp_t    m_out_c0;
    comp_t    m_out_c1;
    comp_t    m_out_c2;
    comp_t    m_out_c3;
    logic     m_last_of_image;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = '0;
    size_t    cfg_data  = '0;

    // typed-in expectation travels with the item it belongs to
    logic     chk_typed = 1'b0;
    box_avg_t chk_want  = '0;

    // predictor state
    size_t                     cfg_width_q  = size_t'(1);
    size_t                     cfg_height_q = size_t'(1);
    logic [CC_W-1:0]           cfg_comps_q  = CC_W'(4);
    int                        col_pos      = 0;
    int                        row_pos      = 0;
    pix_t                      held_q       = '0;
    pair_t [NUM_COMP-1:0]      pair_line [LINE_DEPTH];

    box_avg_t    pending_avgs [$];
    int          n_pixels  = 0;
    int          n_checked = 0;
    int          n_writes  = 0;
    int          n_stalls  = 0;
    int          n_errors  = 0;
    int          cycles    = 0;

    logic        hold_req  = 1'b0;
    int          hold_left = 0;
    rx_mode_t    rx_mode   = RX_OPEN;
    int          rx_left   = 0;
    int          rx_tick   = 0;

    logic        no_gaps    = 1'b0;
    int          burst_left = 0;

    int          big_w [4] = '{8191, 4096, 1, 3};
    int          big_h [4] = '{2, 1, 8191, 4096};

    function automatic dir_row_t pix_row(input pix_t px);
        dir_row_t r;
        r = '0;
        r.kind = ROW_PIX;
        r.pix  = px;
        return r;
    endfunction

    function automatic dir_row_t pix_chk(input pix_t px, input pix_t want, input logic eoi);
        dir_row_t r;
        r = pix_row(px);
        r.typed     = 1'b1;
        r.want.comp = want;
        r.want.eoi  = eoi;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_idx_t idx, input size_t data);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    dir_row_t dir_rows [34] = '{
        pix_chk(32'hffffffff, 32'hffffffff, 1'b1),
        pix_chk(32'h00000000, 32'h00000000, 1'b1),
        pix_chk(32'h80015aa5, 32'h80015aa5, 1'b1),
        cfg_row(CFG_COMP_COUNT, 13'd1),
        pix_chk(32'hffffffff, 32'h000000ff, 1'b1),
        cfg_row(CFG_COMP_COUNT, 13'd0),
        pix_chk(32'h12345678, 32'h00000078, 1'b1),
        cfg_row(CFG_COMP_COUNT, 13'h1fff),
        pix_chk(32'hdeadbeef, 32'hdeadbeef, 1'b1),
        cfg_row(CFG_SRC_WIDTH, 13'd2),
        cfg_row(CFG_SRC_HEIGHT, 13'd2),
        pix_row(32'hffffffff),
        pix_row(32'hffffffff),
        pix_row(32'hffffffff),
        pix_chk(32'hffffffff, 32'hffffffff, 1'b1),
        pix_row(32'h01020300),
        pix_row(32'h00010203),
        pix_row(32'h03000102),
        pix_row(32'h02030001),
        cfg_row(CFG_SRC_WIDTH, 13'd3),
        cfg_row(CFG_SRC_HEIGHT, 13'd3),
        pix_row(32'h00ff00ff),
        pix_row(32'hff00ff00),
        pix_row(32'h7f807f80),
        pix_row(32'h11223344),
        pix_row(32'h55667788),
        pix_row(32'h99aabbcc),
        pix_row(32'hddeeff00),
        pix_row(32'h01010101),
        pix_row(32'hfefefefe),
        cfg_row(CFG_UNUSED_IDX, 13'h1fff),
        cfg_row(CFG_SRC_WIDTH, 13'd0),
        cfg_row(CFG_SRC_HEIGHT, 13'd0),
        pix_chk(32'h0badcafe, 32'h0badcafe, 1'b1)
    };

    box_downsample_2x2_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_c0         (s_in_c0),
        .s_in_c1         (s_in_c1),
        .s_in_c2         (s_in_c2),
        .s_in_c3         (s_in_c3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_c0        (m_out_c0),
        .m_out_c1        (m_out_c1),
        .m_out_c2        (m_out_c2),
        .m_out_c3        (m_out_c3),
        .m_last_of_image (m_last_of_image),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int clip_dim(input size_t v, input int maxv);
        int r;
        if (v == '0) begin
            r = 1;
        end else if (int'(v) > maxv) begin
            r = maxv;
        end else begin
            r = int'(v);
        end
        return r;
    endfunction

    task automatic restart_image();
        col_pos = 0;
        row_pos = 0;
        held_q  = '0;
    endtask

    task automatic apply_reg(input cfg_idx_t idx, input size_t data);
        case (idx)
            CFG_SRC_WIDTH:  cfg_width_q  = data;
            CFG_SRC_HEIGHT: cfg_height_q = data;
            CFG_COMP_COUNT: cfg_comps_q  = data[CC_W-1:0];
            default: ;
        endcase
        if (idx != CFG_UNUSED_IDX) begin
            restart_image();
        end
    endtask

    // one source pixel in, at most one averaged 2x2 block out
    task automatic predict_box_avg(input pix_t px, output logic hit, output box_avg_t res);
        int   w, h, cc, wout, hout, ox, oy, k;
        int   cur  [NUM_COMP];
        int   pair [NUM_COMP];
        int   sum  [NUM_COMP];
        logic have_pair;
        w    = clip_dim(cfg_width_q, MAX_WIDTH);
        h    = clip_dim(cfg_height_q, MAX_HEIGHT);
        cc   = (cfg_comps_q == 0) ? 1 : (int'(cfg_comps_q) > NUM_COMP) ? NUM_COMP
                                                                         : int'(cfg_comps_q);
        wout = ((w >> 1) != 0) ? (w >> 1) : 1;
        hout = ((h >> 1) != 0) ? (h >> 1) : 1;
        ox   = 0;
        oy   = 0;
        hit  = 1'b0;
        res  = '0;
        have_pair = 1'b0;
        for (k = 0; k < NUM_COMP; k++) begin
            cur[k]  = (k < cc) ? int'(px[k]) : 0;
            pair[k] = 0;
            sum[k]  = 0;
        end
        if (w == 1) begin
            // single column counts twice
            if (col_pos == 0) begin
                for (k = 0; k < NUM_COMP; k++) pair[k] = 2 * cur[k];
                have_pair = 1'b1;
            end
        end else if (col_pos % 2 == 1) begin
            if ((col_pos >> 1) < wout) begin
                for (k = 0; k < NUM_COMP; k++) pair[k] = int'(held_q[k]) + cur[k];
                ox = col_pos >> 1;
                have_pair = 1'b1;
            end
        end else begin
            for (k = 0; k < NUM_COMP; k++) held_q[k] = comp_t'(cur[k]);
        end
        if (have_pair) begin
            if (h == 1) begin
                if (row_pos == 0) begin
                    for (k = 0; k < NUM_COMP; k++) sum[k] = 2 * pair[k];
                    hit = 1'b1;
                end
            end else if ((row_pos >> 1) < hout) begin
                if (row_pos % 2 == 0) begin
                    for (k = 0; k < NUM_COMP; k++) pair_line[ox][k] = pair_t'(pair[k]);
                end else begin
                    for (k = 0; k < NUM_COMP; k++) sum[k] = int'(pair_line[ox][k]) + pair[k];
                    oy  = row_pos >> 1;
                    hit = 1'b1;
                end
            end
        end
        if (hit) begin
            for (k = 0; k < NUM_COMP; k++) res.comp[k] = (k < cc) ? comp_t'(sum[k] >> 2) : '0;
            res.eoi = (ox == wout - 1) && (oy == hout - 1);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endtask

    // predictor and scoreboard, both driven from what the handshakes accept
    always @(posedge aclk) begin
        box_avg_t got_avg;
        box_avg_t want_avg;
        pix_t     seen;
        logic     hit;
        int       k;
        if (!aresetn) begin
            cfg_width_q  = size_t'(1);
            cfg_height_q = size_t'(1);
            cfg_comps_q  = CC_W'(4);
            restart_image();
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
                n_writes++;
            end
            if (s_valid && !s_ready) begin
                n_stalls++;
            end
            if (s_valid && s_ready) begin
                predict_box_avg({s_in_c3, s_in_c2, s_in_c1, s_in_c0}, hit, got_avg);
                if (chk_typed) begin
                    pending_avgs.push_back(chk_want);
                end else if (hit) begin
                    pending_avgs.push_back(got_avg);
                end
                n_pixels++;
            end
            if (m_valid && m_ready) begin
                seen = {m_out_c3, m_out_c2, m_out_c1, m_out_c0};
                if (pending_avgs.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected item, expected none, got %h last %b",
                             $time, seen, m_last_of_image);
                end else begin
                    want_avg = pending_avgs.pop_front();
                    n_checked++;
                    for (k = 0; k < NUM_COMP; k++) begin
                        if (seen[k] !== want_avg.comp[k]) begin
                            n_errors++;
                            $display("%0t: out_c%0d expected %02h got %02h",
                                     $time, k, want_avg.comp[k], seen[k]);
                        end
                    end
                    if (m_last_of_image !== want_avg.eoi) begin
                        n_errors++;
                        $display("%0t: last_of_image expected %b got %b",
                                 $time, want_avg.eoi, m_last_of_image);
                    end
                end
            end
        end
    end

    // receiver: changing ready patterns, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 256);
                rx_tick = 0;
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_PULSE:  m_ready <= ((rx_tick % 5) < 2);
                default:   m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycles, pending_avgs.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic pix_t rand_pixel();
        pix_t px;
        int   k;
        for (k = 0; k < NUM_COMP; k++) begin
            case ($urandom_range(0, 9))
                0:       px[k] = 8'h00;
                1:       px[k] = 8'hff;
                default: px[k] = comp_t'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic send_pixel(input pix_t px, input logic typed, input box_avg_t want);
        s_valid   <= 1'b1;
        s_in_c0   <= px[0];
        s_in_c1   <= px[1];
        s_in_c2   <= px[2];
        s_in_c3   <= px[3];
        chk_typed <= typed;
        chk_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // bursts of random length with random gaps in between, unless no_gaps is set
    task automatic pace();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            if (!no_gaps) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // nothing in flight: input idle, every result back, pipeline drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        // let the scoreboard log the last accepted item first
        @(posedge aclk);
        while (pending_avgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input size_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_regs(input size_t wd, input size_t hd, input size_t cd);
        int start, j;
        start = $urandom_range(0, 2);
        wait_idle();
        for (j = 0; j < 3; j++) begin
            case ((start + j) % 3)
                0:       write_reg(CFG_SRC_WIDTH, wd);
                1:       write_reg(CFG_SRC_HEIGHT, hd);
                default: write_reg(CFG_COMP_COUNT, cd);
            endcase
        end
    endtask

    task automatic send_image(input int npix);
        int i;
        for (i = 0; i < npix; i++) begin
            send_pixel(rand_pixel(), 1'b0, '0);
            pace();
        end
    endtask

    initial begin
        dir_row_t row;
        size_t    wd, hd, cd;
        int       i, img, nimg, full, npix, rand_items;
        rand_items = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset defaults, count clamps, rounding, odd sizes
        for (i = 0; i < $size(dir_rows); i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                send_pixel(row.pix, row.typed, row.want);
                pace();
            end
        end

        // receiver holds off while the sender keeps offering
        program_regs(13'd16, 13'd8, 13'd4);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        send_image(16 * 8);
        no_gaps  = 1'b0;
        wait_idle();

        // random small images, some cut short or run past the end
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 15))
                0:       wd = 13'd0;
                1:       wd = 13'd1;
                2:       wd = 13'd2;
                default: wd = size_t'($urandom_range(1, 14));
            endcase
            case ($urandom_range(0, 15))
                0:       hd = 13'd0;
                1:       hd = 13'd1;
                2:       hd = 13'd2;
                default: hd = size_t'($urandom_range(1, 9));
            endcase
            cd = ($urandom_range(0, 4) == 0) ? size_t'($urandom_range(0, 8191))
                                             : size_t'($urandom_range(1, 4));
            program_regs(wd, hd, cd);
            full = clip_dim(wd, MAX_WIDTH) * clip_dim(hd, MAX_HEIGHT);
            nimg = $urandom_range(1, 3);
            for (img = 0; img < nimg; img++) begin
                npix = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * full) : full;
                send_image(npix);
                rand_items += npix;
            end
        end

        // the first pixels of images at and beyond the size limits
        for (i = 0; i < 4; i++) begin
            program_regs(size_t'(big_w[i]), size_t'(big_h[i]),
                         size_t'($urandom_range(1, 4)));
            send_image(BIG_PIXELS);
        end

        wait_idle();
        $display("run covered %0d source pixels and %0d register writes", n_pixels, n_writes);
        $display("%0d averaged items checked, input stalled for %0d cycles",
                 n_checked, n_stalls);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
